/* rtl/oaht_pkg.sv */
// Shared types and constants for the open addressing hash table.
// Holds field widths, request/status/probe-mode codes, the control state
// enum and the packed table entry. No dependencies.
package oaht_pkg;

  localparam int DEFAULT_TABLE_SLOTS = 16;

  localparam int OP_W       = 2;
  localparam int KEY_W      = 31;
  localparam int VALUE_W    = 32;
  localparam int STATUS_W   = 3;
  localparam int SLOT_OUT_W = 4;
  localparam int MODE_W     = 2;

  // Second hash is HASH2_BASE - (key mod HASH2_BASE)
  localparam int HASH2_BASE = 7;
  localparam int REM7_W     = 3;

  // Key reduction: padded key consumed a few bits per cycle, MSB first
  localparam int KEY_PAD_W  = 32;
  localparam int DIGIT_W    = 4;
  localparam int HASH_STEPS = KEY_PAD_W / DIGIT_W;
  localparam int HCNT_W     = $clog2(HASH_STEPS);

  localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OP_W-1:0] OP_SEARCH = 2'd1;
  localparam logic [OP_W-1:0] OP_DELETE = 2'd2;

  localparam logic [MODE_W-1:0] MODE_LINEAR    = 2'd0;
  localparam logic [MODE_W-1:0] MODE_QUADRATIC = 2'd1;
  localparam logic [MODE_W-1:0] MODE_DOUBLE    = 2'd2;

  localparam logic [STATUS_W-1:0] ST_INSERTED  = 3'd0;
  localparam logic [STATUS_W-1:0] ST_UPDATED   = 3'd1;
  localparam logic [STATUS_W-1:0] ST_FULL      = 3'd2;
  localparam logic [STATUS_W-1:0] ST_EXHAUSTED = 3'd3;
  localparam logic [STATUS_W-1:0] ST_FOUND     = 3'd4;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd5;
  localparam logic [STATUS_W-1:0] ST_DELETED   = 3'd6;

  typedef enum logic [2:0] {
    OAHT_CLEAR,
    OAHT_IDLE,
    OAHT_HASH,
    OAHT_PREP,
    OAHT_PROBE
  } state_e;

  typedef struct packed {
    logic               used;
    logic               tomb;
    logic [KEY_W-1:0]   key;
    logic [VALUE_W-1:0] value;
  } entry_t;

endpackage

/* rtl/open_addressing_hash_table.sv */
// Open addressing hash table with tombstones, one table memory and a sequencer.
// Depends on oaht_pkg (widths, codes, state enum, entry type).
//
// Usage:
//   Request channel: drive operation_i, key_i and value_in_i with start high;
//   the transfer happens at a rising edge where start is high and busy is low.
//   Result channel: done_o pulses for exactly one cycle with status_o, slot_o
//   and value_out_o. The receiver cannot stall; it must take the result then.
//   Config: cfg_we_i writes cfg_wdata_i into probe_mode (0 linear, 1 quadratic,
//   2 double hashing, 3 behaves as linear). Write only while the block is idle.
// Operation:
//   After reset the block sweeps the table memory, clearing every entry;
//   busy stays high meanwhile.
//   Per request: the HASH state reduces the key (4 bits per cycle for key
//   mod TABLE_SLOTS and key mod 7), the PREP state sets up the probe, then
//   the PROBE state makes one read of the table memory per probe.
//   An insert into a full table or an unused opcode strobes its result from
//   PREP without probing; any other request probes at most TABLE_SLOTS slots.
//   A new request can be taken in the same cycle as the result strobe.
module open_addressing_hash_table
  import oaht_pkg::*;
#(
  parameter int TABLE_SLOTS = DEFAULT_TABLE_SLOTS
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start,
  output logic                  busy,
  input  logic [OP_W-1:0]       operation_i,
  input  logic [KEY_W-1:0]      key_i,
  input  logic [VALUE_W-1:0]    value_in_i,
  input  logic                  cfg_we_i,
  input  logic [MODE_W-1:0]     cfg_wdata_i,
  output logic                  done_o,
  output logic [STATUS_W-1:0]   status_o,
  output logic [SLOT_OUT_W-1:0] slot_o,
  output logic [VALUE_W-1:0]    value_out_o
);

  localparam int SLOT_W = $clog2(TABLE_SLOTS);
  localparam int CNT_W  = $clog2(TABLE_SLOTS + 1);
  localparam int STEP_W = SLOT_W + 4;

  localparam logic [SLOT_W:0]   SLOTS_EXT  = (SLOT_W + 1)'(TABLE_SLOTS);
  localparam logic [SLOT_W-1:0] LAST_SLOT  = SLOT_W'(TABLE_SLOTS - 1);
  localparam logic [CNT_W-1:0]  SLOTS_CNT  = CNT_W'(TABLE_SLOTS);
  localparam logic [HCNT_W-1:0] LAST_HASH  = HCNT_W'(HASH_STEPS - 1);

  // Add two residues mod TABLE_SLOTS; the sum stays below twice the size.
  function automatic logic [SLOT_W-1:0] mod_add(input logic [SLOT_W:0] a,
                                                input logic [SLOT_W:0] b);
    logic [SLOT_W:0] sum;
    sum = a + b;
    if (sum >= SLOTS_EXT) begin
      sum = sum - SLOTS_EXT;
    end
    return sum[SLOT_W-1:0];
  endfunction

  // Control state
  state_e              state_q, state_d;
  logic [MODE_W-1:0]   probe_mode_q;
  logic [CNT_W-1:0]    live_q, live_d;
  logic [SLOT_W-1:0]   clr_q, clr_d;
  logic                done_q, done_d;

  // Request and working registers
  logic [OP_W-1:0]      op_q, op_d;
  logic [KEY_W-1:0]     key_q, key_d;
  logic [VALUE_W-1:0]   val_q, val_d;
  logic [KEY_PAD_W-1:0] key_sh_q, key_sh_d;
  logic [HCNT_W-1:0]    hcnt_q, hcnt_d;
  logic [SLOT_W-1:0]    remn_q, remn_d;
  logic [REM7_W-1:0]    rem7_q, rem7_d;
  logic [SLOT_W-1:0]    pos_q, pos_d;
  logic [SLOT_W-1:0]    inc_q, inc_d;
  logic [SLOT_W-1:0]    pcnt_q, pcnt_d;
  logic [STATUS_W-1:0]  status_q, status_d;
  logic [SLOT_OUT_W-1:0] slot_q, slot_d;
  logic [VALUE_W-1:0]   vout_q, vout_d;

  // Table memory: one write port, one read port, registered read data
  entry_t              mem [TABLE_SLOTS];
  logic                rd_en;
  logic [SLOT_W-1:0]   rd_addr;
  entry_t              rd_q;
  logic                wr_en;
  logic [SLOT_W-1:0]   wr_addr;
  entry_t              wr_data;

  // Combinational helpers
  logic [SLOT_W-1:0]   remn_nx;
  logic [REM7_W-1:0]   rem7_nx;
  logic [SLOT_W-1:0]   inc_init;
  logic                early_fin;
  logic [STATUS_W-1:0] early_status;
  logic                probe_fin;
  logic                probe_wr;
  logic [STATUS_W-1:0] probe_status;
  entry_t              probe_entry;
  logic                live_inc, live_dec;
  logic [SLOT_W-1:0]   pos_nx;
  logic [SLOT_W-1:0]   inc_nx;

  // ---------------------------------------------------------------------
  // Key reduction: shift in DIGIT_W key bits per cycle, keep both residues
  // below their modulus with one conditional subtract per bit.
  // ---------------------------------------------------------------------
  always_comb begin
    logic [SLOT_W:0]   rn;
    logic [REM7_W:0]   r7;
    rn = {1'b0, remn_q};
    r7 = {1'b0, rem7_q};
    for (int b = 0; b < DIGIT_W; b++) begin
      rn = {rn[SLOT_W-1:0], key_sh_q[KEY_PAD_W-1-b]};
      if (rn >= SLOTS_EXT) begin
        rn = rn - SLOTS_EXT;
      end
      r7 = {r7[REM7_W-1:0], key_sh_q[KEY_PAD_W-1-b]};
      if (r7 >= (REM7_W + 1)'(HASH2_BASE)) begin
        r7 = r7 - (REM7_W + 1)'(HASH2_BASE);
      end
    end
    remn_nx = rn[SLOT_W-1:0];
    rem7_nx = r7[REM7_W-1:0];
  end

  // ---------------------------------------------------------------------
  // Probe setup: first increment, and the requests that finish unprobed.
  // Quadratic probing walks squares by adding odd steps 1, 3, 5, ...
  // ---------------------------------------------------------------------
  always_comb begin
    logic [STEP_W-1:0] st;
    st = STEP_W'(HASH2_BASE) - STEP_W'(rem7_q);
    // step is 1..7 and the table has at least two slots: three subtracts
    for (int k = 0; k < 3; k++) begin
      if (st >= STEP_W'(TABLE_SLOTS)) begin
        st = st - STEP_W'(TABLE_SLOTS);
      end
    end
    if (probe_mode_q == MODE_DOUBLE) begin
      inc_init = st[SLOT_W-1:0];
    end else begin
      inc_init = SLOT_W'(1);
    end

    early_fin    = 1'b0;
    early_status = ST_NOT_FOUND;
    case (op_q)
      OP_INSERT: begin
        if (live_q >= SLOTS_CNT) begin
          early_fin    = 1'b1;
          early_status = ST_FULL;
        end
      end
      OP_SEARCH, OP_DELETE: begin
        early_fin = 1'b0;
      end
      default: begin
        early_fin    = 1'b1;
        early_status = ST_NOT_FOUND;
      end
    endcase
  end

  // ---------------------------------------------------------------------
  // Probe decode: judge the entry just read at pos_q.
  // ---------------------------------------------------------------------
  always_comb begin
    logic never_used;
    logic is_free;
    logic key_eq;
    logic live_hit;
    logic last;
    never_used = !rd_q.used && !rd_q.tomb;
    is_free    = !rd_q.used || rd_q.tomb;
    key_eq     = (rd_q.key == key_q);
    live_hit   = rd_q.used && !rd_q.tomb && key_eq;
    last       = (pcnt_q == LAST_SLOT);

    probe_fin    = 1'b0;
    probe_wr     = 1'b0;
    probe_status = ST_NOT_FOUND;
    probe_entry  = rd_q;
    live_inc     = 1'b0;
    live_dec     = 1'b0;

    case (op_q)
      OP_INSERT: begin
        probe_entry.used  = 1'b1;
        probe_entry.tomb  = 1'b0;
        probe_entry.key   = key_q;
        probe_entry.value = val_q;
        if (is_free) begin
          probe_fin    = 1'b1;
          probe_wr     = 1'b1;
          probe_status = ST_INSERTED;
          live_inc     = 1'b1;
        end else if (key_eq) begin
          probe_fin    = 1'b1;
          probe_wr     = 1'b1;
          probe_status = ST_UPDATED;
        end else if (last) begin
          probe_fin    = 1'b1;
          probe_status = ST_EXHAUSTED;
        end
      end
      OP_SEARCH: begin
        if (never_used) begin
          probe_fin = 1'b1;
        end else if (live_hit) begin
          probe_fin    = 1'b1;
          probe_status = ST_FOUND;
        end else if (last) begin
          probe_fin = 1'b1;
        end
      end
      OP_DELETE: begin
        probe_entry.tomb = 1'b1;
        if (never_used) begin
          probe_fin = 1'b1;
        end else if (live_hit) begin
          probe_fin    = 1'b1;
          probe_wr     = 1'b1;
          probe_status = ST_DELETED;
          live_dec     = (live_q != '0);
        end else if (last) begin
          probe_fin = 1'b1;
        end
      end
      default: begin
        probe_fin = 1'b1;
      end
    endcase

    pos_nx = mod_add({1'b0, pos_q}, {1'b0, inc_q});
    if (probe_mode_q == MODE_QUADRATIC) begin
      inc_nx = mod_add({1'b0, inc_q}, (SLOT_W + 1)'(2));
    end else begin
      inc_nx = inc_q;
    end
  end

  // ---------------------------------------------------------------------
  // Next state
  // ---------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    case (state_q)
      OAHT_CLEAR: begin
        if (clr_q == LAST_SLOT) begin
          state_d = OAHT_IDLE;
        end
      end
      OAHT_IDLE: begin
        if (start) begin
          state_d = OAHT_HASH;
        end
      end
      OAHT_HASH: begin
        if (hcnt_q == LAST_HASH) begin
          state_d = OAHT_PREP;
        end
      end
      OAHT_PREP: begin
        state_d = early_fin ? OAHT_IDLE : OAHT_PROBE;
      end
      OAHT_PROBE: begin
        if (probe_fin) begin
          state_d = OAHT_IDLE;
        end
      end
      default: begin
        state_d = OAHT_IDLE;
      end
    endcase
  end

  // ---------------------------------------------------------------------
  // Datapath and memory control. Each request writes the table at most
  // once, in its last probe cycle, and the next request reads only after
  // its hash cycles, so reads never overlap a pending write.
  // ---------------------------------------------------------------------
  always_comb begin
    clr_d    = clr_q;
    live_d   = live_q;
    done_d   = 1'b0;
    op_d     = op_q;
    key_d    = key_q;
    val_d    = val_q;
    key_sh_d = key_sh_q;
    hcnt_d   = hcnt_q;
    remn_d   = remn_q;
    rem7_d   = rem7_q;
    pos_d    = pos_q;
    inc_d    = inc_q;
    pcnt_d   = pcnt_q;
    status_d = status_q;
    slot_d   = slot_q;
    vout_d   = vout_q;
    rd_en    = 1'b0;
    rd_addr  = pos_q;
    wr_en    = 1'b0;
    wr_addr  = pos_q;
    wr_data  = probe_entry;

    case (state_q)
      OAHT_CLEAR: begin
        // zero one entry per cycle
        wr_en   = 1'b1;
        wr_addr = clr_q;
        wr_data = '0;
        clr_d   = clr_q + SLOT_W'(1);
      end
      OAHT_IDLE: begin
        if (start) begin
          op_d     = operation_i;
          key_d    = key_i;
          val_d    = value_in_i;
          key_sh_d = KEY_PAD_W'(key_i);
          hcnt_d   = '0;
          remn_d   = '0;
          rem7_d   = '0;
        end
      end
      OAHT_HASH: begin
        remn_d   = remn_nx;
        rem7_d   = rem7_nx;
        key_sh_d = key_sh_q << DIGIT_W;
        hcnt_d   = hcnt_q + HCNT_W'(1);
      end
      OAHT_PREP: begin
        pos_d  = remn_q;
        inc_d  = inc_init;
        pcnt_d = '0;
        if (early_fin) begin
          done_d   = 1'b1;
          status_d = early_status;
          slot_d   = '0;
          vout_d   = '0;
        end else begin
          rd_en   = 1'b1;
          rd_addr = remn_q;
        end
      end
      OAHT_PROBE: begin
        if (probe_fin) begin
          done_d   = 1'b1;
          status_d = probe_status;
          wr_en    = probe_wr;
          if (probe_status == ST_NOT_FOUND || probe_status == ST_EXHAUSTED) begin
            slot_d = '0;
          end else begin
            slot_d = SLOT_OUT_W'(pos_q);
          end
          vout_d = (probe_status == ST_FOUND) ? rd_q.value : '0;
          if (live_inc) begin
            live_d = live_q + CNT_W'(1);
          end else if (live_dec) begin
            live_d = live_q - CNT_W'(1);
          end
        end else begin
          // advance to the next probe and fetch it
          pos_d   = pos_nx;
          inc_d   = inc_nx;
          pcnt_d  = pcnt_q + SLOT_W'(1);
          rd_en   = 1'b1;
          rd_addr = pos_nx;
        end
      end
      default: begin
        done_d = 1'b0;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= OAHT_CLEAR;
      probe_mode_q <= MODE_LINEAR;
      live_q       <= '0;
      clr_q        <= '0;
      done_q       <= 1'b0;
    end else begin
      state_q <= state_d;
      live_q  <= live_d;
      clr_q   <= clr_d;
      done_q  <= done_d;
      if (cfg_we_i) begin
        probe_mode_q <= cfg_wdata_i;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    op_q     <= op_d;
    key_q    <= key_d;
    val_q    <= val_d;
    key_sh_q <= key_sh_d;
    hcnt_q   <= hcnt_d;
    remn_q   <= remn_d;
    rem7_q   <= rem7_d;
    pos_q    <= pos_d;
    inc_q    <= inc_d;
    pcnt_q   <= pcnt_d;
    status_q <= status_d;
    slot_q   <= slot_d;
    vout_q   <= vout_d;
  end

  // Table memory
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rd_q <= mem[rd_addr];
    end
  end

  assign busy        = (state_q != OAHT_IDLE);
  assign done_o      = done_q;
  assign status_o    = status_q;
  assign slot_o      = slot_q;
  assign value_out_o = vout_q;

endmodule
